// ----- design/rlp_pkg.sv -----
// rlp_pkg: shared types and constants for the RLP item encoder.
// Used by rlp_front, rlp_cmd_fifo, rlp_back and rlp_item_encoder.
package rlp_pkg;

  typedef enum logic [1:0] {
    REQ_STRING  = 2'd0,
    REQ_LIST    = 2'd1,
    REQ_PAYLOAD = 2'd2,
    REQ_UNUSED  = 2'd3
  } req_t;

  localparam logic [7:0] STR_SHORT_TAG  = 8'h80;
  localparam logic [7:0] STR_LONG_TAG   = 8'hb7;
  localparam logic [7:0] LIST_SHORT_TAG = 8'hc0;
  localparam logic [7:0] LIST_LONG_TAG  = 8'hf7;
  localparam logic [7:0] SINGLE_MAX     = 8'h7f;
  localparam logic [63:0] SHORT_LIMIT   = 64'd56;

  localparam int LEN_BYTES = 8;
  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);

  // one back-end command: a leading byte, then nbytes of len_al from the top
  typedef struct packed {
    logic [7:0]  lead;
    logic [3:0]  nbytes;
    logic [63:0] len_al;
  } cmd_t;

endpackage

// ----- design/rlp_front.sv -----
// rlp_front: accepts input items, applies the header rules and the drop flag,
// and emits one command per item that produces output. Depends on rlp_pkg.
module rlp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        in_req_type,
  input  logic [63:0]       in_payload_length,
  input  logic [7:0]        in_first_payload_byte,
  input  logic [7:0]        in_data_byte,
  input  logic              q_full,
  output logic              cmd_push,
  output rlp_pkg::cmd_t     cmd
);

  logic        drop_r, drop_nxt;
  logic        accept;
  logic        emit;
  logic [3:0]  n_v;
  logic [5:0]  shamt;
  logic [7:0]  short_tag, long_tag;
  rlp_pkg::req_t req;

  assign full   = q_full;
  assign accept = push & ~q_full;
  assign req    = rlp_pkg::req_t'(in_req_type);

  always_comb begin
    n_v = 4'd1;
    for (int i = 1; i < rlp_pkg::LEN_BYTES; i++) begin
      if ((in_payload_length >> (8 * i)) != 64'd0) begin
        n_v = 4'(i + 1);
      end
    end
  end

  assign shamt = 6'((rlp_pkg::LEN_BYTES - int'(n_v)) * 8);

  always_comb begin
    short_tag = rlp_pkg::STR_SHORT_TAG;
    long_tag  = rlp_pkg::STR_LONG_TAG;
    if (req == rlp_pkg::REQ_LIST) begin
      short_tag = rlp_pkg::LIST_SHORT_TAG;
      long_tag  = rlp_pkg::LIST_LONG_TAG;
    end
  end

  always_comb begin
    emit       = 1'b0;
    drop_nxt   = drop_r;
    cmd.lead   = short_tag + in_payload_length[7:0];
    cmd.nbytes = 4'd0;
    cmd.len_al = in_payload_length << shamt;
    if (in_payload_length >= rlp_pkg::SHORT_LIMIT) begin
      cmd.lead   = long_tag + {4'd0, n_v};
      cmd.nbytes = n_v;
    end
    case (req)
      rlp_pkg::REQ_STRING: begin
        drop_nxt = 1'b0;
        emit     = 1'b1;
        if (in_payload_length == 64'd1 && in_first_payload_byte == 8'd0) begin
          drop_nxt = 1'b1;
          cmd.lead = rlp_pkg::STR_SHORT_TAG;
        end else if (in_payload_length == 64'd1 &&
                     in_first_payload_byte <= rlp_pkg::SINGLE_MAX) begin
          emit = 1'b0;
        end
      end
      rlp_pkg::REQ_LIST: begin
        drop_nxt = 1'b0;
        emit     = 1'b1;
      end
      rlp_pkg::REQ_PAYLOAD: begin
        drop_nxt   = 1'b0;
        emit       = ~drop_r;
        cmd.lead   = in_data_byte;
        cmd.nbytes = 4'd0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign cmd_push = accept & emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_r <= 1'b0;
    end else if (accept) begin
      drop_r <= drop_nxt;
    end
  end

endmodule

// ----- design/rlp_cmd_fifo.sv -----
// rlp_cmd_fifo: short command queue between front and back.
// Depends on rlp_pkg.
module rlp_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  rlp_pkg::cmd_t wr_cmd,
  output logic          q_full,
  input  logic          rd,
  output logic          q_empty,
  output rlp_pkg::cmd_t rd_cmd
);

  rlp_pkg::cmd_t             mem_r [rlp_pkg::QDEPTH];
  logic [rlp_pkg::QAW-1:0]   wp_r, rp_r;
  logic [rlp_pkg::QAW:0]     cnt_r;
  logic                      do_wr, do_rd;

  assign q_full  = (cnt_r == (rlp_pkg::QAW+1)'(rlp_pkg::QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr & ~q_full;
  assign do_rd   = rd & ~q_empty;
  assign rd_cmd  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= wp_r + 1'b1;
      if (do_rd) rp_r <= rp_r + 1'b1;
      case ({do_wr, do_rd})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- design/rlp_back.sv -----
// rlp_back: takes commands from the queue and emits one byte per cycle
// into the output register while it is empty or popped. Depends on rlp_pkg.
module rlp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  rlp_pkg::cmd_t rd_cmd,
  output logic          rd,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    out_byte,
  output logic          out_last_of_run
);

  logic        valid_r, valid_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  logic [3:0]  rem_r, rem_nxt;
  logic [63:0] sh_r, sh_nxt;
  logic        slot_free;

  assign slot_free = ~valid_r | pop;
  assign empty           = ~valid_r;
  assign out_byte        = byte_r;
  assign out_last_of_run = last_r;

  always_comb begin
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    rem_nxt   = rem_r;
    sh_nxt    = sh_r;
    rd        = 1'b0;
    if (slot_free) begin
      if (rem_r != 4'd0) begin
        valid_nxt = 1'b1;
        byte_nxt  = sh_r[63:56];
        last_nxt  = (rem_r == 4'd1);
        rem_nxt   = rem_r - 4'd1;
        sh_nxt    = sh_r << 8;
      end else if (!q_empty) begin
        rd        = 1'b1;
        valid_nxt = 1'b1;
        byte_nxt  = rd_cmd.lead;
        last_nxt  = (rd_cmd.nbytes == 4'd0);
        rem_nxt   = rd_cmd.nbytes;
        sh_nxt    = rd_cmd.len_al;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rem_r   <= 4'd0;
    end else begin
      valid_r <= valid_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    sh_r   <= sh_nxt;
  end

endmodule

// ----- design/rlp_item_encoder.sv -----
// rlp_item_encoder: RLP length-prefix encoder, one output byte per transfer.
// The first byte of an item passes the command queue, then the output register, before it shows.
// Throughput: one input item per cycle while the 4-entry command queue has room;
// output runs one byte per cycle while pop keeps up; a header is 1 + n bytes (n length bytes, up to 8).
// Reset (rst_n low, synchronous): queue and output register empty, drop flag clear.
// Depends on rlp_pkg, rlp_front, rlp_cmd_fifo, rlp_back.
module rlp_item_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_req_type,
  input  logic [63:0] in_payload_length,
  input  logic [7:0]  in_first_payload_byte,
  input  logic [7:0]  in_data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_last_of_run
);

  logic          q_full, q_empty, cmd_push, rd;
  rlp_pkg::cmd_t cmd, rd_cmd;

  rlp_front u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .push                  (push),
    .full                  (full),
    .in_req_type           (in_req_type),
    .in_payload_length     (in_payload_length),
    .in_first_payload_byte (in_first_payload_byte),
    .in_data_byte          (in_data_byte),
    .q_full                (q_full),
    .cmd_push              (cmd_push),
    .cmd                   (cmd)
  );

  rlp_cmd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (cmd_push),
    .wr_cmd  (cmd),
    .q_full  (q_full),
    .rd      (rd),
    .q_empty (q_empty),
    .rd_cmd  (rd_cmd)
  );

  rlp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .rd_cmd          (rd_cmd),
    .rd              (rd),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// ----- design/rlp_checker.sv -----
// rlp_checker: port-level checks on rlp_item_encoder, bound to the top level.
// Depends on rlp_item_encoder ports only.
module rlp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       out_last_of_run
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("output not empty after reset");

  a_reset_not_full: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("queue full after reset");

  a_stall_holds_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty)
    else $error("result dropped without transfer");

  a_stall_holds_data: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> ($stable(out_byte) && $stable(out_last_of_run)))
    else $error("stalled result changed");

endmodule

bind rlp_item_encoder rlp_checker u_rlp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .push            (push),
  .full            (full),
  .empty           (empty),
  .pop             (pop),
  .out_byte        (out_byte),
  .out_last_of_run (out_last_of_run)
);
